// ===== rtl/affine_matrix_transform_unit_macros.svh =====
// assertion helpers for the transform unit
// both sample on aclk and are off while aresetn is low
`ifndef AFFINE_MATRIX_TRANSFORM_UNIT_MACROS_SVH
`define AFFINE_MATRIX_TRANSFORM_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define AMTU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define AMTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/amtu_pkg.sv =====
`timescale 1ns / 1ps

package amtu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int REQ_W         = 3;
    localparam int TRIG_W        = 18;
    localparam int COORD_W       = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_IDENTITY  = 3'd0,
        REQ_ROT_X     = 3'd1,
        REQ_ROT_Y     = 3'd2,
        REQ_ROT_Z     = 3'd3,
        REQ_TRANSLATE = 3'd4,
        REQ_POINT     = 3'd5
    } req_t;

    typedef struct packed {
        req_t                       req_type;
        logic signed [TRIG_W-1:0]   cos_value;
        logic signed [TRIG_W-1:0]   sin_value;
        logic signed [COORD_W-1:0]  x_value;
        logic signed [COORD_W-1:0]  y_value;
        logic signed [COORD_W-1:0]  z_value;
    } item_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef coord_t mat_t [4][4];
    typedef coord_t vec3_t [3];

    function automatic mat_t ident_mat(input coord_t one_val);
        mat_t m;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                m[i][j] = (i == j) ? one_val : '0;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/amtu_datapath.sv =====
`timescale 1ns / 1ps

module amtu_datapath
    import amtu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  item_t  item_i,
    input  mat_t   mat_i,
    output mat_t   mat_next_o,
    output vec3_t  pt_o
);

    localparam int RT_W   = TRIG_W + 1;
    localparam int RP_W   = RT_W + COORD_W;
    localparam int TP_W   = 2 * COORD_W;
    localparam int ACC_W  = 2 * COORD_W + 2;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam coord_t ONE_VAL = COORD_W'(1) << FRAC_BITS;
    localparam coord_t MAX_VAL = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t MIN_VAL = {1'b1, {(COORD_W-1){1'b0}}};

    // round half up to the output grid, then clamp to 32 bits
    function automatic coord_t rnd_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = (acc + HALF) >>> FRAC_BITS;
        if (sh[ACC_W-1:COORD_W-1] == {(ACC_W-COORD_W+1){sh[COORD_W-1]}}) begin
            return sh[COORD_W-1:0];
        end else if (sh[ACC_W-1]) begin
            return MIN_VAL;
        end else begin
            return MAX_VAL;
        end
    endfunction

    logic signed [RT_W-1:0] c_ext;
    logic signed [RT_W-1:0] s_ext;
    logic signed [RT_W-1:0] s_eff;
    coord_t                 row_p [4];
    coord_t                 row_q [4];
    logic signed [RP_W-1:0] cp [4];
    logic signed [RP_W-1:0] sq [4];
    logic signed [RP_W-1:0] cq [4];
    logic signed [RP_W-1:0] sp [4];
    logic signed [TP_W-1:0] px [4];
    logic signed [TP_W-1:0] py [4];
    logic signed [TP_W-1:0] pz [4];
    coord_t                 rot_p [4];
    coord_t                 rot_q [4];
    coord_t                 trn [4];

    // the two rows a rotation mixes
    always_comb begin
        c_ext = {item_i.cos_value[TRIG_W-1], item_i.cos_value};
        s_ext = {item_i.sin_value[TRIG_W-1], item_i.sin_value};
        s_eff = (item_i.req_type == REQ_ROT_Y) ? -s_ext : s_ext;
        unique case (item_i.req_type)
            REQ_ROT_Y: begin
                row_p = mat_i[0];
                row_q = mat_i[2];
            end
            REQ_ROT_Z: begin
                row_p = mat_i[0];
                row_q = mat_i[1];
            end
            default: begin
                row_p = mat_i[1];
                row_q = mat_i[2];
            end
        endcase
    end

    // per column: rotation pair and the x,y,z,1 row product
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            cp[j]    = RP_W'(c_ext) * RP_W'(row_p[j]);
            sq[j]    = RP_W'(s_eff) * RP_W'(row_q[j]);
            cq[j]    = RP_W'(c_ext) * RP_W'(row_q[j]);
            sp[j]    = RP_W'(s_eff) * RP_W'(row_p[j]);
            rot_p[j] = rnd_sat(ACC_W'(cp[j]) + ACC_W'(sq[j]));
            rot_q[j] = rnd_sat(ACC_W'(cq[j]) - ACC_W'(sp[j]));
            px[j]    = TP_W'(item_i.x_value) * TP_W'(mat_i[0][j]);
            py[j]    = TP_W'(item_i.y_value) * TP_W'(mat_i[1][j]);
            pz[j]    = TP_W'(item_i.z_value) * TP_W'(mat_i[2][j]);
            trn[j]   = rnd_sat(ACC_W'(px[j]) + ACC_W'(py[j]) + ACC_W'(pz[j])
                               + (ACC_W'(mat_i[3][j]) <<< FRAC_BITS));
        end
    end

    always_comb begin
        mat_next_o = mat_i;
        unique case (item_i.req_type)
            REQ_IDENTITY: begin
                mat_next_o = ident_mat(ONE_VAL);
            end
            REQ_ROT_X: begin
                mat_next_o[1] = rot_p;
                mat_next_o[2] = rot_q;
            end
            REQ_ROT_Y: begin
                mat_next_o[0] = rot_p;
                mat_next_o[2] = rot_q;
            end
            REQ_ROT_Z: begin
                mat_next_o[0] = rot_p;
                mat_next_o[1] = rot_q;
            end
            REQ_TRANSLATE: begin
                mat_next_o[3] = trn;
            end
            default: begin
                mat_next_o = mat_i;
            end
        endcase
    end

    // a point is the same x,y,z,1 row product, first three columns
    assign pt_o[0] = trn[0];
    assign pt_o[1] = trn[1];
    assign pt_o[2] = trn[2];

endmodule

// ===== rtl/affine_matrix_transform_unit.sv =====
`timescale 1ns / 1ps
`include "affine_matrix_transform_unit_macros.svh"

//  channel  | direction | ports                                             | beat
//  ---------+-----------+---------------------------------------------------+-----------------
//  s_       | in        | s_valid s_ready s_req_type s_cos/sin/x/y/z_value  | one command
//  m_       | out       | m_valid m_ready m_out_x m_out_y m_out_z           | one point result
//
//  one command per cycle unless stalled: a beat is captured into the input register
//  and is applied to the matrix in the next cycle through one multiply-add pass
//  synchronous active-low reset loads the identity matrix and empties both stages
//  only point commands produce a result beat; the input stage stalls on a point
//  only while the result register is full and m_ready is low
//  matrix commands never wait on the result side

module affine_matrix_transform_unit
    import amtu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [REQ_W-1:0]           s_req_type,
    input  logic signed [TRIG_W-1:0]   s_cos_value,
    input  logic signed [TRIG_W-1:0]   s_sin_value,
    input  logic signed [COORD_W-1:0]  s_x_value,
    input  logic signed [COORD_W-1:0]  s_y_value,
    input  logic signed [COORD_W-1:0]  s_z_value,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [COORD_W-1:0]  m_out_x,
    output logic signed [COORD_W-1:0]  m_out_y,
    output logic signed [COORD_W-1:0]  m_out_z
);

    localparam coord_t ONE_VAL = COORD_W'(1) << FRAC_BITS;

    // input stage
    logic   in_valid_reg;
    logic   in_valid_next;
    item_t  in_item_reg;

    // stored transform, row major
    mat_t   matrix_reg;
    mat_t   mat_next;

    // result stage
    logic   m_valid_reg;
    logic   m_valid_next;
    coord_t out_x_reg;
    coord_t out_y_reg;
    coord_t out_z_reg;

    vec3_t  pt;
    logic   is_point;
    logic   out_free;
    logic   fire;

    amtu_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .item_i     (in_item_reg),
        .mat_i      (matrix_reg),
        .mat_next_o (mat_next),
        .pt_o       (pt)
    );

    // a point needs room in the result register, everything else goes through
    assign is_point = (in_item_reg.req_type == REQ_POINT);
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && (!is_point || out_free);
    assign s_ready  = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire && is_point) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state and matrix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            matrix_reg   <= ident_mat(ONE_VAL);
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (fire) begin
                matrix_reg <= mat_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.req_type  <= req_t'(s_req_type);
            in_item_reg.cos_value <= s_cos_value;
            in_item_reg.sin_value <= s_sin_value;
            in_item_reg.x_value   <= s_x_value;
            in_item_reg.y_value   <= s_y_value;
            in_item_reg.z_value   <= s_z_value;
        end
        if (fire && is_point) begin
            out_x_reg <= pt[0];
            out_y_reg <= pt[1];
            out_z_reg <= pt[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;
    assign m_out_z = out_z_reg;

    // a result beat only ever comes from a point command
    `AMTU_ASSERT_NEXT(a_no_spurious_result, !(fire && is_point) && out_free,
        !m_valid_reg, "result beat without a point command")

    // a point never overwrites a result that was not taken
    `AMTU_ASSERT_SAME(a_no_result_overrun, fire && is_point,
        !m_valid_reg || m_ready, "point result overwrote a pending beat")

    // a stalled command stays put in the input register
    `AMTU_ASSERT_NEXT(a_input_held, in_valid_reg && !fire,
        in_valid_reg && $stable(in_item_reg), "stalled command was lost or changed")

    // identity reload puts one on the diagonal
    `AMTU_ASSERT_NEXT(a_identity_load, fire && (in_item_reg.req_type == REQ_IDENTITY),
        (matrix_reg[0][0] == ONE_VAL) && (matrix_reg[3][3] == ONE_VAL)
            && (matrix_reg[3][0] == '0), "identity reload failed")

endmodule
